@@ src/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the byte stuffing codec.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CMD_SLOTS = 4;
    localparam int SLOT_W    = $clog2(CMD_SLOTS);

    // register reset values
    localparam logic [BYTE_W-1:0] RESET_START  = 8'h7B;
    localparam logic [BYTE_W-1:0] RESET_END    = 8'h7D;
    localparam logic [BYTE_W-1:0] RESET_ESCAPE = 8'h40;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_START     = 2'd1,
        CFG_END       = 2'd2,
        CFG_ESCAPE    = 2'd3
    } cfg_reg_t;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // live configuration
    typedef struct packed {
        logic              direction;
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] escape_marker;
    } cfg_t;

    // one classified input: up to four bytes to send, last_idx marks the final one
    typedef struct packed {
        logic [SLOT_W-1:0]                last_idx;
        logic [CMD_SLOTS-1:0][BYTE_W-1:0] bytes;
    } cmd_t;

endpackage

@@ src/bsc_front.sv @@
// ----------------------------------------------------------------------------
// bsc_front
// Accepts input bytes, tracks frame and escape state and turns each byte
// into a command of one to four output bytes, or drops it.
// ----------------------------------------------------------------------------
module bsc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bsc_pkg::cfg_t             cfg,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bsc_pkg::BYTE_W-1:0] s_tdata,
    input  logic                      s_tlast,
    input  logic                      q_full,
    output logic                      q_push,
    output bsc_pkg::cmd_t             q_cmd
);
    import bsc_pkg::*;

    logic                              in_frame_reg, in_frame_next;
    logic                              esc_pend_reg, esc_pend_next;
    logic                              accept;
    logic                              has_out;
    logic                              is_marker;
    logic [SLOT_W-1:0]                 ptr;
    logic [CMD_SLOTS-1:0][BYTE_W-1:0]  slots;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign is_marker = (s_tdata == cfg.start_marker) || (s_tdata == cfg.end_marker) ||
                       (s_tdata == cfg.escape_marker);

    // classify the byte and build its output list
    always_comb begin
        slots         = '0;
        ptr           = '0;
        has_out       = 1'b0;
        in_frame_next = in_frame_reg;
        esc_pend_next = esc_pend_reg;
        if (cfg.direction == DIR_ENCODE) begin
            has_out = 1'b1;
            if (!in_frame_reg) begin
                slots[ptr] = cfg.start_marker;
                ptr        = ptr + 1'b1;
            end
            if (is_marker) begin
                slots[ptr] = cfg.escape_marker;
                ptr        = ptr + 1'b1;
                slots[ptr] = s_tdata ^ cfg.escape_marker;
            end else begin
                slots[ptr] = s_tdata;
            end
            if (s_tlast) begin
                ptr           = ptr + 1'b1;
                slots[ptr]    = cfg.end_marker;
                in_frame_next = 1'b0;
            end else begin
                in_frame_next = 1'b1;
            end
        end else begin
            if (s_tdata == cfg.start_marker) begin
                slots[0]      = s_tdata;
                has_out       = 1'b1;
                in_frame_next = 1'b1;
                esc_pend_next = 1'b0;
            end else if (in_frame_reg) begin
                if (esc_pend_reg) begin
                    slots[0]      = s_tdata ^ cfg.escape_marker;
                    has_out       = 1'b1;
                    esc_pend_next = 1'b0;
                end else if (s_tdata == cfg.escape_marker) begin
                    esc_pend_next = 1'b1;
                end else if (s_tdata == cfg.end_marker) begin
                    slots[0]      = s_tdata;
                    has_out       = 1'b1;
                    in_frame_next = 1'b0;
                end else begin
                    slots[0] = s_tdata;
                    has_out  = 1'b1;
                end
            end
        end
    end

    assign q_push         = accept && has_out;
    assign q_cmd.bytes    = slots;
    assign q_cmd.last_idx = ptr;

    // frame and escape state, updated per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
        end else if (accept) begin
            in_frame_reg <= in_frame_next;
            esc_pend_reg <= esc_pend_next;
        end
    end

endmodule

@@ src/bsc_queue.sv @@
// ----------------------------------------------------------------------------
// bsc_queue
// Small register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module bsc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bsc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output bsc_pkg::cmd_t head_cmd
);
    import bsc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/bsc_back.sv @@
// ----------------------------------------------------------------------------
// bsc_back
// Takes commands from the queue and sends their bytes one per cycle while
// m_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module bsc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_not_empty,
    input  bsc_pkg::cmd_t              q_cmd,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bsc_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import bsc_pkg::*;

    cmd_t                cur_reg, cur_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic                load, cur_done;

    assign load     = cur_valid_reg && (!out_valid_reg || m_tready);
    assign cur_done = load && (idx_reg == cur_reg.last_idx);
    assign q_pop    = q_not_empty && (!cur_valid_reg || cur_done);

    // command slot and output register
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_reg.bytes[idx_reg];
            out_last_next  = cur_done;
            idx_next       = idx_reg + 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (cur_done) begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/byte_stuffing_codec.sv @@
// ----------------------------------------------------------------------------
// byte_stuffing_codec
// Frame byte stuffing encoder / decoder with programmable markers.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------
//  s_       | in        | tdata: data_byte[7:0]; tlast: frame_last
//  m_       | out       | tdata: out_byte[7:0];  tlast: run_last
//  cfg_     | in        | cfg_index (register), cfg_data (value)
//
//  One input byte is taken per cycle while the command queue has room.
//  The back end sends one output byte per cycle while m_tready is high, so
//  an input that expands to n bytes makes n registered output transfers.
//  Reset is synchronous on aresetn; no clearing pass is needed.
//  Input and output stall independently through the QUEUE_DEPTH queue.
// ----------------------------------------------------------------------------
module byte_stuffing_codec #(
    parameter int QUEUE_DEPTH = 4   // 2 and up
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [bsc_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bsc_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [bsc_pkg::BYTE_W-1:0] cfg_data
);
    import bsc_pkg::*;

    cfg_t   cfg_reg;
    cmd_t   push_cmd, head_cmd;
    logic   q_push, q_pop, q_full, q_not_empty;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction     <= DIR_ENCODE;
            cfg_reg.start_marker  <= RESET_START;
            cfg_reg.end_marker    <= RESET_END;
            cfg_reg.escape_marker <= RESET_ESCAPE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DIRECTION: cfg_reg.direction     <= cfg_data[0];
                CFG_START:     cfg_reg.start_marker  <= cfg_data;
                CFG_END:       cfg_reg.end_marker    <= cfg_data;
                CFG_ESCAPE:    cfg_reg.escape_marker <= cfg_data;
            endcase
        end
    end

    bsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    bsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    bsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

@@ src/bsc_checker.sv @@
// ----------------------------------------------------------------------------
// bsc_checker
// Port level checks for the byte stuffing codec, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_ready
);

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // reset empties the output stage
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // reset empties the queue, so input is open right after
    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // configuration writes are never refused
    a_cfg_open: assert property (@(posedge aclk) cfg_ready)
        else $error("configuration port stalled");

endmodule

bind byte_stuffing_codec bsc_checker u_bsc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

@@ test/byte_stuffing_codec_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_codec_check
// Watches the input, output and register channels of the stuffing codec.
// Keeps its own copy of the markers, direction and framing state, works out
// the bytes each accepted input must produce, and compares every output
// transfer against the oldest of them.
// ----------------------------------------------------------------------------
module byte_stuffing_codec_check
    import bsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,
    input  logic              m_tlast,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    output int                failures,
    output int                outstanding
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
    } coded_byte_t;

    coded_byte_t expected_bytes [$];
    cfg_t        regs;
    logic        in_frame;
    logic        escape_pending;
    int          printed = 0;

    task automatic report_mismatch(input string what);
        if (printed < 40) $display("%0t ns: %s", $time, what);
        printed++;
        failures++;
    endtask

    // stuff (encode) or strip (decode) one byte and queue what must come out
    function automatic void stuff_or_strip(input logic [BYTE_W-1:0] data,
                                           input logic last);
        logic [BYTE_W-1:0] run [$];
        coded_byte_t       item;
        if (regs.direction == DIR_ENCODE) begin
            if (!in_frame) begin
                run.push_back(regs.start_marker);
                in_frame = 1'b1;
            end
            if (data == regs.start_marker || data == regs.end_marker ||
                data == regs.escape_marker) begin
                run.push_back(regs.escape_marker);
                run.push_back(data ^ regs.escape_marker);
            end else begin
                run.push_back(data);
            end
            if (last) begin
                run.push_back(regs.end_marker);
                in_frame = 1'b0;
            end
        end else begin
            // start wins over everything, then a pending escape, escape, end
            if (data == regs.start_marker) begin
                run.push_back(data);
                in_frame       = 1'b1;
                escape_pending = 1'b0;
            end else if (in_frame) begin
                if (escape_pending) begin
                    run.push_back(data ^ regs.escape_marker);
                    escape_pending = 1'b0;
                end else if (data == regs.escape_marker) begin
                    escape_pending = 1'b1;
                end else if (data == regs.end_marker) begin
                    run.push_back(data);
                    in_frame = 1'b0;
                end else begin
                    run.push_back(data);
                end
            end
        end
        for (int i = 0; i < run.size(); i++) begin
            item.out_byte = run[i];
            item.run_last = (i == run.size() - 1);
            expected_bytes.push_back(item);
        end
    endfunction

    // one process per edge: registers, then outputs, then the new input
    always @(posedge aclk) begin : watch
        coded_byte_t want;
        if (!aresetn) begin
            regs           = {DIR_ENCODE, RESET_START, RESET_END, RESET_ESCAPE};
            in_frame       = 1'b0;
            escape_pending = 1'b0;
            failures       = 0;
            expected_bytes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_DIRECTION: regs.direction     = cfg_data[0];
                    CFG_START:     regs.start_marker  = cfg_data;
                    CFG_END:       regs.end_marker    = cfg_data;
                    CFG_ESCAPE:    regs.escape_marker = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %h last %b",
                                              m_tdata, m_tlast));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.out_byte)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_tdata, want.out_byte));
                    if (m_tlast !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b (byte %h)",
                                                  m_tlast, want.run_last, want.out_byte));
                end
            end
            if (s_tvalid && s_tready) stuff_or_strip(s_tdata, s_tlast);
        end
        outstanding = expected_bytes.size();
    end

endmodule

@@ test/byte_stuffing_codec_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_codec_test
// Drives the stuffing codec through a directed pass over marker bytes,
// escapes, framing corner cases and direction changes, then through random
// phases of encode runs and decode line frames under several marker
// settings, with bursty input and a stalling output. The checker beside the
// block predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module byte_stuffing_codec_test;
    import bsc_pkg::*;

    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [3:0] MASK_ALL      = 4'hF;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [BYTE_W-1:0] cfg_data;

    int failures;
    int outstanding;

    // register values last written, used to shape the stimulus
    logic              cur_dir    = DIR_ENCODE;
    logic [BYTE_W-1:0] cur_start  = RESET_START;
    logic [BYTE_W-1:0] cur_end    = RESET_END;
    logic [BYTE_W-1:0] cur_escape = RESET_ESCAPE;

    int items_sent  = 0;
    int burst_left  = 1;
    int idle_cycles = 0;

    logic [15:0] ready_pattern;
    int          pattern_age = 0;

    byte_stuffing_codec DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] data_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] out_byte
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    byte_stuffing_codec_check stuffing_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // receiver back-pressure: a random 16-bit ready pattern, replaced when pattern_age runs out
    always @(posedge aclk) begin
        if (pattern_age == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : 16'($urandom) | 16'h0001;
            pattern_age = 64;
        end
        pattern_age--;
        m_tready <= ready_pattern[pattern_age % 16];
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("byte_stuffing_codec_test failed");
            $finish;
        end
    end

    // one input transfer; bursts of random length with random gaps after them
    task automatic send_item(input logic [BYTE_W-1:0] data, input logic last,
                             input bit counted = 1'b1);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (counted) items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if ($urandom_range(0, 4) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    // hold off input until every expected byte is out and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write the registers selected in the mask, in index order
    task automatic set_registers(input logic [3:0] mask, input logic dir,
                                 input logic [BYTE_W-1:0] st,
                                 input logic [BYTE_W-1:0] en,
                                 input logic [BYTE_W-1:0] es);
        logic [BYTE_W-1:0] values [4];
        values[CFG_DIRECTION] = {7'd0, dir};
        values[CFG_START]     = st;
        values[CFG_END]       = en;
        values[CFG_ESCAPE]    = es;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_reg_t'(i);
                cfg_data  <= values[i];
                do @(posedge aclk); while (!cfg_ready);
            end
        end
        cfg_valid <= 1'b0;
        if (mask[CFG_DIRECTION]) cur_dir    = dir;
        if (mask[CFG_START])     cur_start  = st;
        if (mask[CFG_END])       cur_end    = en;
        if (mask[CFG_ESCAPE])    cur_escape = es;
    endtask

    // payload byte that hits one of the markers fairly often
    function automatic logic [BYTE_W-1:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return cur_start;
            1:       return cur_end;
            2:       return cur_escape;
            default: return 8'($urandom);
        endcase
    endfunction

    // well-formed line frame: start, stuffed payload, end
    task automatic send_line_frame(input int len);
        logic [BYTE_W-1:0] b;
        send_item(cur_start, 1'($urandom));
        repeat (len) begin
            b = pick_payload();
            if (b == cur_start || b == cur_end || b == cur_escape) begin
                send_item(cur_escape, 1'($urandom));
                send_item(b ^ cur_escape, 1'($urandom));
            end else begin
                send_item(b, 1'($urandom));
            end
        end
        send_item(cur_end, 1'($urandom));
    endtask

    initial begin
        logic [BYTE_W-1:0] st, en, es;
        int                goal;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // encode with reset markers: extremes, each marker escaped, longest run
        send_item(8'h00, 1'b0);
        send_item(8'h7B, 1'b0);
        send_item(8'h7D, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h7B, 1'b1);

        // decode: bytes outside a frame dropped, start after an escape,
        // escape swallowed, end echoed
        drain_results();
        set_registers(4'b1 << CFG_DIRECTION, DIR_DECODE, 8'h00, 8'h00, 8'h00);
        send_item(8'h11, 1'b1);
        send_item(8'h7D, 1'b0);
        send_item(8'h7B, 1'b0);
        send_item(8'h40, 1'b1);
        send_item(8'h7B, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'h3D, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h7D, 1'b1);

        // pending escape survives a trip through encode mode
        send_item(8'h7B, 1'b0);
        send_item(8'h40, 1'b0);
        drain_results();
        set_registers(4'b1 << CFG_DIRECTION, DIR_ENCODE, 8'h00, 8'h00, 8'h00);
        send_item(8'h55, 1'b0);
        drain_results();
        set_registers(4'b1 << CFG_DIRECTION, DIR_DECODE, 8'h00, 8'h00, 8'h00);
        send_item(8'h3D, 1'b0);

        // end equal to escape: escape takes priority over end
        drain_results();
        set_registers(4'b1 << CFG_END, DIR_DECODE, 8'h00, 8'h40, 8'h00);
        send_item(8'h40, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'h7D, 1'b0);

        // start equal to escape: start takes priority
        drain_results();
        set_registers(4'b1 << CFG_START, DIR_DECODE, 8'h40, 8'h00, 8'h00);
        send_item(8'h40, 1'b1);

        // encode with extreme marker values and a zero escape mask
        drain_results();
        set_registers(MASK_ALL, DIR_ENCODE, 8'h00, 8'hFF, 8'h00);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);

        // random phases, each under its own register setting
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin st = RESET_START; en = RESET_END; es = RESET_ESCAPE; end
                1: begin st = 8'h00; en = 8'hFF; es = 8'h80; end
                2: begin st = 8'hFF; en = 8'h00; es = 8'hFF; end
                default: begin
                    st = 8'($urandom);
                    en = 8'($urandom);
                    es = ($urandom_range(0, 3) == 0) ? en : 8'($urandom);
                end
            endcase
            drain_results();
            set_registers(MASK_ALL, 1'(phase % 2), st, en, es);
            goal = items_sent + 22;
            while (items_sent < goal) begin
                if (cur_dir == DIR_ENCODE) begin
                    send_item(pick_payload(), $urandom_range(0, 5) == 0);
                end else begin
                    case ($urandom_range(0, 9))
                        // stray line noise
                        0: send_item(8'($urandom), 1'($urandom), 1'b0);
                        // broken frame: cut off right after an escape
                        1: begin
                            send_item(cur_start, 1'($urandom));
                            send_item(pick_payload(), 1'($urandom));
                            send_item(cur_escape, 1'($urandom));
                        end
                        default: send_line_frame($urandom_range(0, 6));
                    endcase
                end
            end
        end

        drain_results();
        if (failures == 0)
            $display("byte_stuffing_codec_test passed");
        else
            $display("byte_stuffing_codec_test failed");
        $finish;
    end

endmodule
